// ===== rtl/bloom_filter_two_hash_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Bloom filter unit assertion macros
// Concurrent assertion helpers shared by the bloom filter RTL.
// ---------------------------------------------------------------------------
`ifndef BLOOM_FILTER_TWO_HASH_UNIT_MACROS_SVH
`define BLOOM_FILTER_TWO_HASH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define BFTH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define BFTH_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BFTH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define BFTH_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/bfth_pkg.sv =====
// ---------------------------------------------------------------------------
// Bloom filter package
// Payload types and constants of the two-hash bloom filter unit.
// ---------------------------------------------------------------------------
package bfth_pkg;

   localparam int BFTH_MAX_BITS_DEF = 4096;   // default store depth
   localparam int BFTH_FILTER_RESET = 4096;   // filter size after reset
   localparam int BFTH_FILTER_W     = 13;     // width of the size register
   localparam int BFTH_HASH_W       = 32;
   localparam int BFTH_STEP_BITS    = 4;      // quotient bits per divider step
   localparam int BFTH_DIV_STEPS    = BFTH_HASH_W / BFTH_STEP_BITS;
   localparam int BFTH_STEP_CNT_W   = $clog2(BFTH_DIV_STEPS);

   localparam logic BFTH_CMD_ADD    = 1'b0;
   localparam logic BFTH_CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] key_byte;
      logic       key_last;
   } req_type;

   typedef struct packed {
      logic found;
      logic was_lookup;
   } rsp_type;

endpackage

// ===== rtl/bloom_filter_two_hash_unit.sv =====
// ---------------------------------------------------------------------------
// Bloom filter with two string hashes
// Streams key characters into two running hashes and sets or tests two bits
// of a single-bit store at the end of each key.
// ---------------------------------------------------------------------------
// Use: each req beat carries one key character, the command and a last flag.
// A beat that is not the last of its key folds the character into both
// hashes, and the next beat may follow at once. A last beat starts the key
// end: each hash magnitude is reduced modulo the filter size by one shared
// restoring divider that retires four quotient bits a cycle, first for one
// hash and then for the other; then the store is written (add) or read
// (lookup) through its single port at the two bit addresses, and the result
// is loaded into the rsp register. From the last req beat to rsp_valid,
// req_ready is low. The filter size is written through csr_wr_en and
// csr_wr_data and applies to keys finished afterwards.
// After reset all MAX_BITS entries of the store are swept to zero, one entry
// a cycle, before the first req beat is taken. If the receiver stalls, the
// finished result waits in the rsp register; further characters are still
// taken, and the next key end holds its result until the register frees.
// ---------------------------------------------------------------------------
`include "bloom_filter_two_hash_unit_macros.svh"

module bloom_filter_two_hash_unit
   import bfth_pkg::*;
#(
   parameter int MAX_BITS = BFTH_MAX_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_wr_en,
   input  logic [BFTH_FILTER_W-1:0] csr_wr_data
);

   localparam int NW      = $clog2(MAX_BITS + 1);   // width of the modulus
   localparam int AW      = $clog2(MAX_BITS);       // store address width
   localparam int EFF_RST = (BFTH_FILTER_RESET > MAX_BITS) ? MAX_BITS
                                                           : BFTH_FILTER_RESET;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV_A,
      S_DIV_B,
      S_MEM_A,
      S_MEM_B,
      S_CHECK,
      S_OUT
   } state_type;

   state_type                  state_ff;
   logic [NW-1:0]              eff_ff;
   logic [NW-1:0]              eff_in;
   logic [BFTH_HASH_W-1:0]     h17_ff;
   logic [BFTH_HASH_W-1:0]     h29_ff;
   logic [BFTH_HASH_W-1:0]     h17_in;
   logic [BFTH_HASH_W-1:0]     h29_in;
   logic [BFTH_HASH_W-1:0]     char_ext;
   logic [BFTH_HASH_W-1:0]     mag17;
   logic [BFTH_HASH_W-1:0]     mag29;
   logic [BFTH_HASH_W-1:0]     mag_b_ff;
   logic [BFTH_HASH_W-1:0]     num_ff;
   logic [BFTH_HASH_W-1:0]     num_in;
   logic [NW-1:0]              rem_ff;
   logic [NW-1:0]              rem_in;
   logic [BFTH_STEP_CNT_W-1:0] step_ff;
   logic                       step_done;
   logic [AW-1:0]              idx_a_ff;
   logic [AW-1:0]              idx_b_ff;
   logic [AW-1:0]              clr_ff;
   logic                       cmd_ff;
   logic                       bit_a_ff;
   logic                       found_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff;
   logic                       req_fire;

   logic                       mem [MAX_BITS];
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic                       mem_wdata;
   logic [AW-1:0]              mem_raddr;
   logic                       mem_rd_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A size of zero acts as one; sizes beyond the store are clipped to it.
   always_comb begin
      if (csr_wr_data == '0) begin
         eff_in = NW'(1);
      end else if (32'(csr_wr_data) > 32'(MAX_BITS)) begin
         eff_in = NW'(MAX_BITS);
      end else begin
         eff_in = NW'(csr_wr_data);
      end
   end

   // Character fold by shift and add: h*17 = 16h + h, h*29 = 32h - 4h + h.
   always_comb begin
      char_ext = {{(BFTH_HASH_W - 8){req_data.key_byte[7]}}, req_data.key_byte};
      if (req_data.key_byte != 8'd0) begin
         h17_in = (h17_ff << 4) + h17_ff + char_ext;
         h29_in = (h29_ff << 5) - (h29_ff << 2) + h29_ff + char_ext;
      end else begin
         h17_in = h17_ff;
         h29_in = h29_ff;
      end
      mag17 = h17_in[BFTH_HASH_W-1] ? (~h17_in + 1'b1) : h17_in;
      mag29 = h29_in[BFTH_HASH_W-1] ? (~h29_in + 1'b1) : h29_in;
   end

   // Shared restoring divider: several quotient bits per cycle, remainder only.
   always_comb begin
      logic [NW:0]            r_v;
      logic [BFTH_HASH_W-1:0] n_v;
      r_v = {1'b0, rem_ff};
      n_v = num_ff;
      for (int i = 0; i < BFTH_STEP_BITS; i++) begin
         r_v = {r_v[NW-1:0], n_v[BFTH_HASH_W-1]};
         n_v = n_v << 1;
         if (r_v >= {1'b0, eff_ff}) begin
            r_v = r_v - {1'b0, eff_ff};
         end
      end
      rem_in = r_v[NW-1:0];
      num_in = n_v;
   end

   assign step_done = (step_ff == BFTH_STEP_CNT_W'(BFTH_DIV_STEPS - 1));

   // Single store port: clearing sweep, or the two bit reads and add writes.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_a_ff;
      mem_wdata = 1'b1;
      mem_raddr = idx_a_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 1'b0;
         end
         S_MEM_A: begin
            mem_we = (cmd_ff == BFTH_CMD_ADD);
         end
         S_MEM_B: begin
            mem_we    = (cmd_ff == BFTH_CMD_ADD);
            mem_waddr = idx_b_ff;
            mem_raddr = idx_b_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         eff_ff       <= NW'(EFF_RST);
         h17_ff       <= '0;
         h29_ff       <= '0;
         clr_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            eff_ff <= eff_in;
         end
         // The output step handles its own handshake below.
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(MAX_BITS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  if (req_data.key_last) begin
                     h17_ff   <= '0;
                     h29_ff   <= '0;
                     cmd_ff   <= req_data.cmd;
                     num_ff   <= mag17;
                     mag_b_ff <= mag29;
                     rem_ff   <= '0;
                     step_ff  <= '0;
                     state_ff <= S_DIV_A;
                  end else begin
                     h17_ff <= h17_in;
                     h29_ff <= h29_in;
                  end
               end
            end
            S_DIV_A: begin
               if (step_done) begin
                  idx_a_ff <= AW'(rem_in);
                  num_ff   <= mag_b_ff;
                  rem_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= S_DIV_B;
               end else begin
                  num_ff  <= num_in;
                  rem_ff  <= rem_in;
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_DIV_B: begin
               if (step_done) begin
                  idx_b_ff <= AW'(rem_in);
                  step_ff  <= '0;
                  state_ff <= S_MEM_A;
               end else begin
                  num_ff  <= num_in;
                  rem_ff  <= rem_in;
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_MEM_A: begin
               state_ff <= S_MEM_B;
            end
            S_MEM_B: begin
               // Read data of the first address is available here.
               bit_a_ff <= mem_rd_ff;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               found_ff <= (cmd_ff == BFTH_CMD_LOOKUP) && bit_a_ff && mem_rd_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_data_ff.found      <= found_ff;
                  rsp_data_ff.was_lookup <= cmd_ff;
                  state_ff               <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `BFTH_ASSERT_NXT(a_last_blocks, clock, reset,
      req_fire && req_data.key_last, !req_ready,
      "key end did not stall the request channel")
   `BFTH_ASSERT_IMP(a_rsp_from_out, clock, reset,
      $rose(rsp_valid), $past(state_ff == S_OUT),
      "result raised outside the output step")
   `BFTH_ASSERT_IMP(a_store_write, clock, reset,
      mem_we,
      (state_ff == S_CLEAR) || ((state_ff == S_MEM_A || state_ff == S_MEM_B)
                                && cmd_ff == BFTH_CMD_ADD),
      "store written outside the clearing sweep or an add")

endmodule

// ===== dv/bloom_filter_two_hash_unit_tb.sv =====
// ---------------------------------------------------------------------------
// Bloom filter two-hash unit testbench
// Streams keys one character per beat, adds them to the filter and looks
// them up again under several filter sizes and idling patterns. An in-bench
// model of the hashes and the bit store predicts every result, and a checker
// compares each delivered result with the oldest prediction.
// ---------------------------------------------------------------------------
module bloom_filter_two_hash_unit_tb;
   import bfth_pkg::*;

   localparam int unsigned ITEM_TARGET    = 1550;
   localparam int unsigned KEY_END_CYCLES = 24;
   localparam int unsigned SETTLE_CYCLES  = 2 * KEY_END_CYCLES;
   localparam int unsigned STUCK_LIMIT    = 20000;
   localparam int unsigned MAX_PRINTED    = 40;
   localparam int unsigned KEY_MAX_LEN    = 12;
   localparam int unsigned KEEP_KEYS      = 48;

   typedef struct packed {
      logic [3:0]              len;
      logic [11:0][7:0]        chars;
   } key_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_wr_en = 1'b0;
   logic [BFTH_FILTER_W-1:0] csr_wr_data = '0;

   // Model state: size register, running hashes and the bit store.
   logic [BFTH_FILTER_W-1:0] filter_size = BFTH_FILTER_W'(BFTH_FILTER_RESET);
   logic [31:0]              hash17 = '0;
   logic [31:0]              hash29 = '0;
   logic                     bit_store [BFTH_MAX_BITS_DEF];

   rsp_type                  expected_results [$];
   rsp_type                  oldest_result;
   key_type                  added_keys [$];

   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned error_count       = 0;
   int unsigned items_accepted    = 0;
   int unsigned keys_added        = 0;
   int unsigned keys_looked_up    = 0;
   int unsigned found_seen        = 0;
   int unsigned stuck_cycles      = 0;

   bloom_filter_two_hash_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < BFTH_MAX_BITS_DEF; i++) bit_store[i] = 1'b0;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Store slot addressed by a hash: its magnitude as an unsigned value, so
   // that the most negative hash gives 2^31, reduced by the effective size.
   function automatic int unsigned store_slot(input logic [31:0] hash);
      logic [31:0] magnitude;
      logic [31:0] modulus;
      magnitude = hash[31] ? 32'd0 - hash : hash;
      modulus   = (filter_size == '0) ? 32'd1 :
                  (filter_size > BFTH_MAX_BITS_DEF) ? 32'(BFTH_MAX_BITS_DEF) :
                  32'(filter_size);
      return int'(magnitude % modulus);
   endfunction

   function automatic void fold_beat(input req_type beat);
      logic [31:0] ch;
      int unsigned slot_a;
      int unsigned slot_b;
      rsp_type     outcome;
      if (beat.key_byte != 8'd0) begin
         ch     = {{24{beat.key_byte[7]}}, beat.key_byte};
         hash17 = hash17 * 32'd17 + ch;
         hash29 = hash29 * 32'd29 + ch;
      end
      if (beat.key_last) begin
         slot_a = store_slot(hash17);
         slot_b = store_slot(hash29);
         outcome.was_lookup = beat.cmd;
         outcome.found      = 1'b0;
         if (beat.cmd == BFTH_CMD_ADD) begin
            bit_store[slot_a] = 1'b1;
            bit_store[slot_b] = 1'b1;
         end else begin
            outcome.found = bit_store[slot_a] && bit_store[slot_b];
         end
         expected_results.push_back(outcome);
         hash17 = '0;
         hash29 = '0;
      end
   endfunction

   // Valid is only lowered when the sender idles, so back-to-back beats keep
   // it high without a second assignment in the same step.
   task automatic send_beat(input req_type beat);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= req_type'($urandom);
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      items_accepted++;
      fold_beat(beat);
   endtask

   task automatic send_key(input key_type key, input logic cmd);
      req_type beat;
      for (int i = 0; i < key.len; i++) begin
         beat.key_byte = key.chars[i];
         beat.key_last = (i == key.len - 1);
         beat.cmd      = beat.key_last ? cmd : logic'($urandom_range(1));
         send_beat(beat);
      end
      if (cmd == BFTH_CMD_ADD) keys_added++;
      else keys_looked_up++;
   endtask

   task automatic drain_results(input int unsigned settle);
      req_valid <= 1'b0;
      req_data  <= req_type'($urandom);
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_filter_size(input logic [BFTH_FILTER_W-1:0] size);
      drain_results(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      filter_size  = size;
   endtask

   task automatic set_idling(input int unsigned sender, input int unsigned receiver);
      sender_idle_pct    = sender;
      receiver_stall_pct = receiver;
   endtask

   function automatic key_type make_key(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] c2, input int unsigned len);
      key_type key;
      key          = '0;
      key.len      = 4'(len);
      key.chars[0] = c0;
      key.chars[1] = c1;
      key.chars[2] = c2;
      return key;
   endfunction

   // Writes 2^31 in bijective base 17 or 29, so the digits are never zero and
   // the running hash of that base lands exactly on the most negative value.
   function automatic key_type key_hashing_to_min(input int unsigned base);
      key_type     key;
      longint      rest;
      longint      digit;
      logic [7:0]  digits [KEY_MAX_LEN];
      int unsigned count;
      rest  = 64'sd2147483648;
      count = 0;
      while (rest != 0) begin
         digit = rest % longint'(base);
         if (digit == 0) digit = longint'(base);
         digits[count] = 8'(digit);
         count++;
         rest = (rest - digit) / longint'(base);
      end
      key     = '0;
      key.len = 4'(count);
      for (int i = 0; i < count; i++) key.chars[i] = digits[count - 1 - i];
      return key;
   endfunction

   function automatic key_type random_key();
      key_type key;
      key     = '0;
      if ($urandom_range(19) == 0) begin
         key.len = 4'd1;
         return key;
      end
      key.len = 4'($urandom_range(1, 8));
      for (int i = 0; i < key.len; i++) begin
         key.chars[i] = 8'($urandom_range(1, 255));
         if ($urandom_range(29) == 0) key.chars[i] = 8'd0;
      end
      // A trailing zero beat closes the key without adding a character.
      if ($urandom_range(9) == 0) key.len = key.len + 4'd1;
      return key;
   endfunction

   task automatic test_empty_store();
      send_key(make_key("A", 8'd0, 8'd0, 1), BFTH_CMD_LOOKUP);
   endtask

   task automatic test_key_bytes();
      send_key(make_key(8'h7F, 8'h80, 8'd0, 2), BFTH_CMD_ADD);
      send_key(make_key(8'hFF, 8'h01, 8'h00, 3), BFTH_CMD_ADD);
      send_key(make_key(8'h00, 8'd0, 8'd0, 1), BFTH_CMD_ADD);
      send_key(make_key(8'h7F, 8'h80, 8'd0, 2), BFTH_CMD_LOOKUP);
   endtask

   task automatic test_filter_size_limits();
      write_filter_size('0);
      send_key(make_key(8'h55, 8'd0, 8'd0, 1), BFTH_CMD_LOOKUP);
      write_filter_size('1);
      send_key(make_key(8'h00, 8'd0, 8'd0, 1), BFTH_CMD_LOOKUP);
   endtask

   task automatic test_most_negative_hash();
      write_filter_size(BFTH_FILTER_W'(3001));
      send_key(key_hashing_to_min(17), BFTH_CMD_ADD);
      send_key(key_hashing_to_min(29), BFTH_CMD_LOOKUP);
   endtask

   task automatic test_random_traffic();
      int unsigned round;
      int unsigned pick;
      key_type     key;
      round = 0;
      while (items_accepted < ITEM_TARGET) begin
         case (round % 4)
            0: set_idling(0, 0);
            1: set_idling(88, 0);
            2: set_idling(0, 88);
            default: set_idling(14, 14);
         endcase
         case (round % 8)
            0: write_filter_size(BFTH_FILTER_W'(BFTH_FILTER_RESET));
            1: write_filter_size(BFTH_FILTER_W'(1));
            2: write_filter_size('1);
            3: write_filter_size(BFTH_FILTER_W'(64));
            4: write_filter_size(BFTH_FILTER_W'($urandom_range(2, 4095)));
            5: write_filter_size(BFTH_FILTER_W'($urandom_range(4097, 8190)));
            6: write_filter_size(BFTH_FILTER_W'(1000));
            default: write_filter_size('0);
         endcase
         for (int k = 0; k < 40 && items_accepted < ITEM_TARGET; k++) begin
            pick = $urandom_range(99);
            if (pick < 6) drain_results(0);
            if (pick < 45 || added_keys.size() == 0) begin
               key = random_key();
               send_key(key, BFTH_CMD_ADD);
               added_keys.push_back(key);
               if (added_keys.size() > KEEP_KEYS) void'(added_keys.pop_front());
            end else if (pick < 80) begin
               send_key(added_keys[$urandom_range(added_keys.size() - 1)],
                        BFTH_CMD_LOOKUP);
            end else begin
               send_key(random_key(), BFTH_CMD_LOOKUP);
            end
         end
         round++;
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result beat with nothing expected", 32'(rsp_data), 0);
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_data.found !== oldest_result.found)
               report_mismatch("found", 32'(rsp_data.found), 32'(oldest_result.found));
            if (rsp_data.was_lookup !== oldest_result.was_lookup)
               report_mismatch("was_lookup", 32'(rsp_data.was_lookup),
                               32'(oldest_result.was_lookup));
            if (oldest_result.found) found_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Timeout: no beat accepted for %0d cycles", STUCK_LIMIT);
         $display("bloom_filter_two_hash_unit_tb: done, errors");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_store();
      test_key_bytes();
      test_filter_size_limits();
      test_most_negative_hash();
      test_random_traffic();
      drain_results(SETTLE_CYCLES);
      $display("Covered %0d character beats: %0d keys added, %0d looked up, %0d found.",
               items_accepted, keys_added, keys_looked_up, found_seen);
      $display("Filter sizes from 0 to 8191 under four idling patterns; %0d mismatches.",
               error_count);
      if (error_count == 0) begin
         $display("bloom_filter_two_hash_unit_tb: done, clean");
      end else begin
         $display("bloom_filter_two_hash_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bfth_pkg.sv
rtl/bloom_filter_two_hash_unit.sv
dv/bloom_filter_two_hash_unit_tb.sv
